@@ rtl/epp_pkg.sv @@
// ----------------------------------------------------------------------------
// epp_pkg: shared types and constants
// Payload structs, sequencer state, operand selects and fixed-point constants
// for the encoder position controller.
// ----------------------------------------------------------------------------
package epp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_PROP   = 2'd1;
    localparam logic [1:0] CFG_SUM    = 2'd2;
    localparam logic [1:0] CFG_PERIOD = 2'd3;

    // Register reset values
    localparam logic signed [31:0] TARGET_RST = 32'sd1000;
    localparam logic [15:0]        PROP_RST   = 16'd26;
    localparam logic [15:0]        SUM_RST    = 16'd26;
    localparam logic [15:0]        PERIOD_RST = 16'd30;

    // Shared multiply-add unit widths
    localparam int MAC_A_W = 34;
    localparam int MAC_B_W = 25;
    localparam int ACC_W   = 52;

    // Full duty in Q8.8: 100 * 256
    localparam int              MAG_W        = 15;
    localparam logic [MAG_W-1:0] DUTY_FULL_Q8 = 15'd25600;
    // mag * period < 2^31
    localparam int PROD_W = 31;
    // floor(y / 100) = (y * ceil(2^30 / 100)) >> 30, exact for y < 2^23
    localparam int                       RECIP_SHIFT = 30;
    localparam logic signed [MAC_B_W-1:0] RECIP_100  = 25'sd10737419;

    typedef struct packed {
        logic operation;
        logic level_a;
        logic level_b;
    } epp_in_t;

    typedef struct packed {
        logic signed [31:0] position_count;
        logic signed [31:0] position_error;
        logic               drive_reverse;
        logic [15:0]        high_time;
        logic               updated;
    } epp_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREV,
        ST_ERR,
        ST_PROP,
        ST_SUM,
        ST_MAG,
        ST_SCALE,
        ST_RECIP,
        ST_DONE
    } epp_state_t;

    typedef enum logic [1:0] {
        A_COUNT,
        A_ERR,
        A_MAG,
        A_PROD
    } a_sel_t;

    typedef enum logic [2:0] {
        B_NEG_ONE,
        B_PROP,
        B_SUM,
        B_PERIOD,
        B_RECIP
    } b_sel_t;

    typedef enum logic [1:0] {
        ADD_ZERO,
        ADD_TARGET,
        ADD_ACC
    } add_sel_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_ACC,
        DST_ERR,
        DST_MAG,
        DST_PROD,
        DST_WIDTH
    } dst_t;

    typedef struct packed {
        a_sel_t   a_sel;
        b_sel_t   b_sel;
        add_sel_t add_sel;
        dst_t     dst;
        logic     out_load;
        logic     idle;
    } epp_ctrl_t;

endpackage

@@ rtl/epp_mac.sv @@
// ----------------------------------------------------------------------------
// epp_mac: shared signed multiply-add
// result = addend + op_a * op_b; the caller registers the result.
// ----------------------------------------------------------------------------
module epp_mac
    import epp_pkg::*;
(
    input  logic signed [MAC_A_W-1:0] op_a,
    input  logic signed [MAC_B_W-1:0] op_b,
    input  logic signed [ACC_W-1:0]   addend,
    output logic signed [ACC_W-1:0]   result
);

    logic signed [MAC_A_W+MAC_B_W-1:0] product;

    assign product = op_a * op_b;
    // all products used here fit in ACC_W bits
    assign result  = addend + ACC_W'(product);

endmodule

@@ rtl/epp_seq.sv @@
// ----------------------------------------------------------------------------
// epp_seq: control sequencer
// Steps a control tick through the shared multiply-add (an encoder event goes
// straight to the done step) and hands the result to the output register.
// ----------------------------------------------------------------------------
module epp_seq
    import epp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_fire,
    input  logic      tick,
    input  logic      out_free,
    output epp_ctrl_t ctrl
);

    epp_state_t state_reg;
    epp_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = tick ? ST_PREV : ST_DONE;
                end
            end
            ST_PREV:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_PROP;
            ST_PROP:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_MAG;
            ST_MAG:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_RECIP;
            ST_RECIP: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '{a_sel: A_ERR, b_sel: B_SUM, add_sel: ADD_ZERO, dst: DST_NONE,
                 out_load: 1'b0, idle: 1'b0};
        case (state_reg)
            ST_IDLE: ctrl.idle = 1'b1;
            ST_PREV: begin
                // previous error times sum gain, before the error is replaced
                ctrl.a_sel = A_ERR;
                ctrl.b_sel = B_SUM;
                ctrl.dst   = DST_ACC;
            end
            ST_ERR: begin
                ctrl.a_sel   = A_COUNT;
                ctrl.b_sel   = B_NEG_ONE;
                ctrl.add_sel = ADD_TARGET;
                ctrl.dst     = DST_ERR;
            end
            ST_PROP: begin
                ctrl.a_sel   = A_ERR;
                ctrl.b_sel   = B_PROP;
                ctrl.add_sel = ADD_ACC;
                ctrl.dst     = DST_ACC;
            end
            ST_SUM: begin
                ctrl.a_sel   = A_ERR;
                ctrl.b_sel   = B_SUM;
                ctrl.add_sel = ADD_ACC;
                ctrl.dst     = DST_ACC;
            end
            ST_MAG: ctrl.dst = DST_MAG;
            ST_SCALE: begin
                ctrl.a_sel = A_MAG;
                ctrl.b_sel = B_PERIOD;
                ctrl.dst   = DST_PROD;
            end
            ST_RECIP: begin
                ctrl.a_sel = A_PROD;
                ctrl.b_sel = B_RECIP;
                ctrl.dst   = DST_WIDTH;
            end
            ST_DONE: ctrl.out_load = out_free;
            default: ctrl.idle = 1'b0;
        endcase
    end

endmodule

@@ rtl/encoder_position_pi_pwm.sv @@
// ----------------------------------------------------------------------------
// encoder_position_pi_pwm: quadrature position counter with PI-style
// position control and PWM width output
//
//   channel   ports                        direction  carries
//   s_        s_valid s_ready s_data       in         encoder event or tick
//   m_        m_valid m_ready m_data       out        count, error, drive
//   cfg_      cfg_we cfg_index cfg_data    in         register writes
//
// An encoder event goes from acceptance straight to the done step, which loads
// the output register once it is free; a control tick first passes through the
// sequencer, stepping one multiply-add unit through 6 passes (previous error,
// error, two gain terms, scale, divide) plus one magnitude step. The input
// reopens the cycle after the load, so a request is finished before the next.
// Synchronous active-low reset clears the count, the held error, direction
// and width, and loads the register defaults.
// The input is taken only while the sequencer is idle; a finished result
// waits in the output register, so the next request is accepted while
// m_ready is low, and the sequencer holds in its last step only when a
// second result arrives before the first is taken.
// ----------------------------------------------------------------------------
module encoder_position_pi_pwm
    import epp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  epp_in_t     s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output epp_out_t    m_data,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic signed [31:0] target_reg, target_next;
    logic [15:0]        prop_reg, prop_next;
    logic [15:0]        sum_reg, sum_next;
    logic [15:0]        period_reg, period_next;

    // controller state
    logic signed [31:0]      count_reg, count_next;
    logic signed [31:0]      err_reg, err_next;
    logic                    rev_reg, rev_next;
    logic [15:0]             width_reg, width_next;
    logic                    tick_reg, tick_next;

    // working registers of the sequence
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;

    // output register
    epp_out_t out_reg, out_next;
    logic     m_valid_reg, m_valid_next;

    epp_ctrl_t ctrl;
    logic      s_fire;
    logic      out_free;

    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   mac_add;
    logic signed [ACC_W-1:0]   mac_res;

    logic signed [31:0]      err_sat;
    logic signed [ACC_W-1:0] acc_abs;

    assign s_ready  = ctrl.idle;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    epp_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_fire   (s_fire),
        .tick     (s_data.operation),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // operand selection for the shared unit
    always_comb begin
        case (ctrl.a_sel)
            A_COUNT: mac_a = MAC_A_W'(count_reg);
            A_ERR:   mac_a = MAC_A_W'(err_reg);
            A_MAG:   mac_a = {{(MAC_A_W-MAG_W){1'b0}}, mag_reg};
            A_PROD:  mac_a = {{(MAC_A_W-PROD_W+8){1'b0}}, prod_reg[PROD_W-1:8]};
            default: mac_a = '0;
        endcase
        case (ctrl.b_sel)
            B_NEG_ONE: mac_b = -25'sd1;
            B_PROP:    mac_b = {{(MAC_B_W-16){1'b0}}, prop_reg};
            B_SUM:     mac_b = {{(MAC_B_W-16){1'b0}}, sum_reg};
            B_PERIOD:  mac_b = {{(MAC_B_W-16){1'b0}}, period_reg};
            B_RECIP:   mac_b = RECIP_100;
            default:   mac_b = '0;
        endcase
        case (ctrl.add_sel)
            ADD_ZERO:   mac_add = '0;
            ADD_TARGET: mac_add = ACC_W'(target_reg);
            ADD_ACC:    mac_add = acc_reg;
            default:    mac_add = '0;
        endcase
    end

    epp_mac u_mac (
        .op_a   (mac_a),
        .op_b   (mac_b),
        .addend (mac_add),
        .result (mac_res)
    );

    // clamp target - count to the 32-bit signed range
    always_comb begin
        if ((mac_res[ACC_W-1:31] == '0) || (mac_res[ACC_W-1:31] == '1)) begin
            err_sat = mac_res[31:0];
        end else if (mac_res[ACC_W-1]) begin
            err_sat = 32'sh8000_0000;
        end else begin
            err_sat = 32'sh7FFF_FFFF;
        end
    end

    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;

    always_comb begin
        target_next  = target_reg;
        prop_next    = prop_reg;
        sum_next     = sum_reg;
        period_next  = period_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        rev_next     = rev_reg;
        width_next   = width_reg;
        tick_next    = tick_reg;
        acc_next     = acc_reg;
        mag_next     = mag_reg;
        prod_next    = prod_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_TARGET: target_next = cfg_data;
                CFG_PROP:   prop_next   = cfg_data[15:0];
                CFG_SUM:    sum_next    = cfg_data[15:0];
                CFG_PERIOD: period_next = cfg_data[15:0];
                default:    target_next = target_reg;
            endcase
        end

        // encoder event: advance on differing levels, step back on equal
        if (s_fire) begin
            tick_next = s_data.operation;
            if (!s_data.operation) begin
                if (s_data.level_a != s_data.level_b) begin
                    count_next = count_reg + 32'sd1;
                end else begin
                    count_next = count_reg - 32'sd1;
                end
            end
        end

        case (ctrl.dst)
            DST_ACC: acc_next = mac_res;
            DST_ERR: err_next = err_sat;
            DST_MAG: begin
                rev_next = acc_reg[ACC_W-1];
                if (acc_abs > ACC_W'(DUTY_FULL_Q8)) begin
                    mag_next = DUTY_FULL_Q8;
                end else begin
                    mag_next = acc_abs[MAG_W-1:0];
                end
            end
            DST_PROD:  prod_next  = mac_res[PROD_W-1:0];
            DST_WIDTH: width_next = mac_res[RECIP_SHIFT +: 16];
            default:   acc_next   = acc_reg;
        endcase

        // drop the delivered result, then load the finished one
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.out_load) begin
            m_valid_next            = 1'b1;
            out_next.position_count = count_reg;
            out_next.position_error = err_reg;
            out_next.drive_reverse  = rev_reg;
            out_next.high_time      = width_reg;
            out_next.updated        = tick_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= TARGET_RST;
            prop_reg    <= PROP_RST;
            sum_reg     <= SUM_RST;
            period_reg  <= PERIOD_RST;
            count_reg   <= '0;
            err_reg     <= '0;
            rev_reg     <= 1'b0;
            width_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            target_reg  <= target_next;
            prop_reg    <= prop_next;
            sum_reg     <= sum_next;
            period_reg  <= period_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            rev_reg     <= rev_next;
            width_reg   <= width_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tick_reg <= tick_next;
        acc_reg  <= acc_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

`ifndef ASSERT_OFF
    // a tick keeps the sequencer busy in the cycle after acceptance
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.operation) |=> !s_ready)
        else $error("input taken again right after a control tick");

    // an encoder event moves the count by exactly one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_data.operation) |=>
        ((count_reg - $past(count_reg) == 32'sd1) ||
         ($past(count_reg) - count_reg == 32'sd1)))
        else $error("encoder event moved the count by other than one");

    // a tick result never drives a pulse longer than the period
    a_width_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.out_load && tick_reg) |=> (out_reg.high_time <= period_reg))
        else $error("pulse width exceeds the period");
`endif

endmodule
